@@ design/smm_pkg.sv @@
package smm_pkg;

    // fixed field widths of the item and result beats
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 4;
    localparam int VALUE_W   = 16;
    localparam int PRODUCT_W = 36;

    // configuration port
    localparam int SIZE_W     = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLUMN_MAJOR = 1'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_C  = 2'd2;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctl_t;

endpackage

@@ design/smm_elem_store.sv @@
module smm_elem_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read: rd_data shows mem[rd_addr] from the cycle after rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/smm_mac.sv @@
module smm_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smm_pkg::mac_ctl_t                 ctl,
    input  logic signed [ELEM_WIDTH-1:0]      a_data,
    input  logic signed [ELEM_WIDTH-1:0]      b_data,
    output logic [smm_pkg::PRODUCT_W-1:0]     acc,
    output logic                              busy
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic signed [PROD_W-1:0]            mul_reg;
    logic                                mul_valid_reg;
    logic [smm_pkg::PRODUCT_W-1:0]       acc_reg;
    logic [smm_pkg::PRODUCT_W-1:0]       acc_next;

    // product register, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.data_valid)
        begin
            mul_reg <= a_data * b_data;
        end
    end

    // sum wraps modulo 2^36
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (mul_valid_reg)
        begin
            acc_next = acc_reg + smm_pkg::PRODUCT_W'(mul_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            mul_valid_reg <= ctl.data_valid;
            acc_reg       <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = mul_valid_reg;

endmodule

@@ design/square_matrix_multiply_core.sv @@
// square matrix multiply core: answers entries of C = A * B one at a time
//
// input channel (in_valid / in_stall): a beat with mode write A or write B
// stores value at (row, col) of that matrix; a write outside
// the store is dropped. a beat with mode read C asks for entry (row, col)
// and gives one result beat; mode 3 is dropped.
// output channel (out_valid / out_stall): product, out_row, out_col.
// for a read the single multiply-accumulate unit walks n element pairs, n
// being size_in_use capped at MAX_N, one pair per cycle out of the A and B
// stores, then waits out read, multiply and accumulate; in_stall stays high
// for the walk. a read outside the store or with size zero answers 0.
// the result sits in an output register; the input side takes further
// beats while it waits, and a following read stalls only at its end if the
// earlier result has still not been taken.
// configuration (cfg_write, cfg_index, cfg_data) is to be written by the user
// only while idle; the core does not enforce it. reset clears control and
// sets size_in_use to 16, b_column_major to 0; the element stores are not
// cleared and hold nothing until written.
module square_matrix_multiply_core #(
    parameter int MAX_N      = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration
    input  logic                                 cfg_write,
    input  logic [smm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smm_pkg::CFG_DATA_W-1:0]       cfg_data,

    // input beats
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [smm_pkg::MODE_W-1:0]           mode,
    input  logic [smm_pkg::COORD_W-1:0]          row,
    input  logic [smm_pkg::COORD_W-1:0]          col,
    input  logic signed [smm_pkg::VALUE_W-1:0]   value,

    // result beats
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [smm_pkg::PRODUCT_W-1:0] product,
    output logic [smm_pkg::COORD_W-1:0]          out_row,
    output logic [smm_pkg::COORD_W-1:0]          out_col
);

    localparam int IDX_W  = $clog2(MAX_N);
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int ADDR_W = 2 * IDX_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // configuration registers
    logic [smm_pkg::SIZE_W-1:0] size_reg;
    logic                       b_col_major_reg;

    // sequencer
    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [IDX_W-1:0]           k_reg;
    logic [IDX_W-1:0]           k_next;
    logic [CNT_W-1:0]           n_reg;
    logic [CNT_W-1:0]           n_next;
    logic [IDX_W-1:0]           row_idx_reg;
    logic [IDX_W-1:0]           col_idx_reg;
    logic [smm_pkg::COORD_W-1:0] req_row_reg;
    logic [smm_pkg::COORD_W-1:0] req_col_reg;
    logic                       rd_valid_reg;

    // output register
    logic                              out_valid_reg;
    logic [smm_pkg::PRODUCT_W-1:0]     product_reg;
    logic [smm_pkg::COORD_W-1:0]       out_row_reg;
    logic [smm_pkg::COORD_W-1:0]       out_col_reg;

    // decode of the incoming beat
    logic                       in_accept;
    logic                       in_inside;
    logic [IDX_W-1:0]           in_row_idx;
    logic [IDX_W-1:0]           in_col_idx;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ELEM_WIDTH-1:0]      wr_elem;
    logic                       wr_a;
    logic                       wr_b;
    logic                       start_read;
    logic [CNT_W-1:0]           n_eff;

    // store reads
    logic                       rd_en;
    logic [ADDR_W-1:0]          a_rd_addr;
    logic [ADDR_W-1:0]          b_rd_addr;
    logic [ELEM_WIDTH-1:0]      a_rd_data;
    logic [ELEM_WIDTH-1:0]      b_rd_data;

    smm_pkg::mac_ctl_t               mac_ctl;
    logic [smm_pkg::PRODUCT_W-1:0]   mac_acc;
    logic                            mac_busy;
    logic                            load_out;
    logic                            out_free;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg        <= smm_pkg::SIZE_RESET;
            b_col_major_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                smm_pkg::REG_SIZE_IN_USE:    size_reg        <= cfg_data;
                smm_pkg::REG_B_COLUMN_MAJOR: b_col_major_reg <= cfg_data[0];
                default:                     size_reg        <= size_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign in_inside  = (32'(row) < MAX_N) && (32'(col) < MAX_N);
    assign in_row_idx = IDX_W'(row);
    assign in_col_idx = IDX_W'(col);
    assign wr_addr    = {in_row_idx, in_col_idx};
    // sign extend or wrap the 16-bit value to the element width
    assign wr_elem    = ELEM_WIDTH'(value);
    assign wr_a       = in_accept && in_inside && (mode == smm_pkg::MODE_WRITE_A);
    assign wr_b       = in_accept && in_inside && (mode == smm_pkg::MODE_WRITE_B);
    assign start_read = in_accept && (mode == smm_pkg::MODE_READ_C);

    // size above MAX_N saturates
    assign n_eff = (32'(size_reg) > MAX_N) ? CNT_W'(MAX_N) : CNT_W'(size_reg);

    // ------------------------------------------------------------------
    // sequencer: one element pair issued per cycle in S_RUN, then wait for
    // the read and multiply stages to empty before handing over the sum
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_read)
                begin
                    k_next = '0;
                    n_next = n_eff;
                    // empty sum for an entry outside the store or size zero
                    if (in_inside && (n_eff != '0))
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN:
            begin
                if ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            n_reg        <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            rd_valid_reg <= rd_en;
        end
    end

    // request coordinates, payload only
    always_ff @(posedge clk)
    begin
        if (start_read)
        begin
            row_idx_reg <= in_row_idx;
            col_idx_reg <= in_col_idx;
            req_row_reg <= row;
            req_col_reg <= col;
        end
    end

    // ------------------------------------------------------------------
    // element stores: row of A, and column of B either across or along
    // ------------------------------------------------------------------
    assign rd_en     = (state_reg == S_RUN);
    assign a_rd_addr = {row_idx_reg, k_reg};
    assign b_rd_addr = b_col_major_reg ? {col_idx_reg, k_reg} : {k_reg, col_idx_reg};

    smm_elem_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_WIDTH)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    smm_elem_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_WIDTH)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_elem),
        .rd_en   (rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // ------------------------------------------------------------------
    // multiply-accumulate, cleared when a read is taken in
    // ------------------------------------------------------------------
    assign mac_ctl.clear      = start_read;
    assign mac_ctl.data_valid = rd_valid_reg;

    smm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rd_data),
        .b_data (b_rd_data),
        .acc    (mac_acc),
        .busy   (mac_busy)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            product_reg <= mac_acc;
            out_row_reg <= req_row_reg;
            out_col_reg <= req_col_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

`ifndef SYNTHESIS
    // accumulator is never cleared while terms are still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.clear |-> (!rd_valid_reg && !mac_busy))
        else $error("accumulator cleared with terms in flight");

    // the walk never issues an index at or beyond the size in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (CNT_W'(k_reg) < n_reg))
        else $error("element index beyond size in use");

    // a result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    // after a read is taken in, the output register holds until the sum is complete
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) && (rd_valid_reg || mac_busy) |=> !load_out || !$past(mac_busy))
        else $error("result handed over before the pipeline emptied");
`endif

endmodule

@@ tb/tb_square_matrix_multiply_core.sv @@
module tb_square_matrix_multiply_core;

    timeunit 1ns;
    timeprecision 1ps;

    // store geometry as built (default parameters of the core)
    localparam int MAX_N = 16;

    // the one mode code the package leaves unnamed, dropped by the core
    localparam logic [smm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 9;
    // long enough for any beat still in the core to finish
    localparam int SETTLE_CYCLES = 32;
    // cycles with no beat on either side before the run is called hung
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASE_ITEMS   = 190;
    localparam int NUM_PHASES    = 8;
    localparam int STALL_SPAN    = 150;

    typedef struct packed {
        logic [smm_pkg::MODE_W-1:0]         mode;
        logic [smm_pkg::COORD_W-1:0]        row;
        logic [smm_pkg::COORD_W-1:0]        col;
        logic signed [smm_pkg::VALUE_W-1:0] value;
    } matrix_beat_t;

    typedef struct {
        logic signed [smm_pkg::PRODUCT_W-1:0] product;
        logic [smm_pkg::COORD_W-1:0]          row;
        logic [smm_pkg::COORD_W-1:0]          col;
    } c_entry_t;

    // ports; every input to the core is known from time zero
    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [smm_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [smm_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic [smm_pkg::MODE_W-1:0]           mode      = '0;
    logic [smm_pkg::COORD_W-1:0]          row       = '0;
    logic [smm_pkg::COORD_W-1:0]          col       = '0;
    logic signed [smm_pkg::VALUE_W-1:0]   value     = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [smm_pkg::PRODUCT_W-1:0] product;
    logic [smm_pkg::COORD_W-1:0]          out_row;
    logic [smm_pkg::COORD_W-1:0]          out_col;

    // beats waiting to be sent, and C entries the core still owes us
    matrix_beat_t matrix_beats [$];
    c_entry_t     c_entries_due [$];

    // predictor copy of the stores and the two registers
    logic signed [smm_pkg::VALUE_W-1:0] a_elem [MAX_N*MAX_N];
    logic signed [smm_pkg::VALUE_W-1:0] b_elem [MAX_N*MAX_N];
    logic [smm_pkg::SIZE_W-1:0]         size_reg  = smm_pkg::SIZE_RESET;
    logic                               col_major = 1'b0;

    // which store cells the stimulus has written so far, so no read ever
    // touches an element left undefined since reset
    bit a_seen [MAX_N*MAX_N];
    bit b_seen [MAX_N*MAX_N];

    // sender burst/gap state, receiver stall state
    int           gap_left   = 0;
    int           burst_left = 1;
    matrix_beat_t next_beat;
    int           stall_age  = 0;
    int           stall_pct  = 0;
    c_entry_t     due;

    int errors         = 0;
    int quiet_cycles   = 0;
    int write_beats    = 0;
    int read_beats     = 0;
    int ignored_beats  = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int pauses         = 0;
    int queued         = 0;
    int phase          = 0;
    int phase_start    = 0;
    int pick           = 0;

    // random settings walked in turn: extremes of the size, both layouts
    int phase_size [NUM_PHASES] = '{16, 31, 1, 0, 5, 16, 2, 12};
    bit phase_cm   [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1};

    square_matrix_multiply_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .product   (product),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // size actually walked by the multiply-accumulate, saturated at the store size
    function automatic int terms_in_use();
        return (size_reg > MAX_N) ? MAX_N : int'(size_reg);
    endfunction

    // predictor: applies one accepted beat to the stores, or works out the
    // C entry it asks for and queues it
    function automatic void apply_matrix_beat(matrix_beat_t b);
        longint   acc;
        int       n;
        c_entry_t e;
        case (b.mode)
            smm_pkg::MODE_WRITE_A:
            begin
                a_elem[b.row*MAX_N + b.col] = b.value;
                write_beats++;
            end
            smm_pkg::MODE_WRITE_B:
            begin
                b_elem[b.row*MAX_N + b.col] = b.value;
                write_beats++;
            end
            smm_pkg::MODE_READ_C:
            begin
                n   = terms_in_use();
                acc = 0;
                // transposed layout keeps B(k, col) at store cell (col, k)
                for (int k = 0; k < n; k++)
                    acc += longint'(a_elem[b.row*MAX_N + k]) *
                           longint'(col_major ? b_elem[b.col*MAX_N + k]
                                              : b_elem[k*MAX_N + b.col]);
                e.product = acc[smm_pkg::PRODUCT_W-1:0];
                e.row     = b.row;
                e.col     = b.col;
                c_entries_due.push_back(e);
                read_beats++;
            end
            default:
                ignored_beats++;
        endcase
    endfunction

    // true when every element the entry needs has been written
    function automatic bit entry_readable(int r, int c);
        int n;
        n = terms_in_use();
        for (int k = 0; k < n; k++)
        begin
            if (!a_seen[r*MAX_N + k])
                return 1'b0;
            if (!(col_major ? b_seen[c*MAX_N + k] : b_seen[k*MAX_N + c]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // element values lean on the extremes
    function automatic logic signed [smm_pkg::VALUE_W-1:0] pick_element();
        case ($urandom_range(7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return -16'sd1;
            default: return smm_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void queue_beat(logic [smm_pkg::MODE_W-1:0] m, int r, int c,
                                       logic signed [smm_pkg::VALUE_W-1:0] v);
        matrix_beat_t b;
        b.mode  = m;
        b.row   = r[smm_pkg::COORD_W-1:0];
        b.col   = c[smm_pkg::COORD_W-1:0];
        b.value = v;
        matrix_beats.push_back(b);
        if (m == smm_pkg::MODE_WRITE_A)
            a_seen[b.row*MAX_N + b.col] = 1'b1;
        else if (m == smm_pkg::MODE_WRITE_B)
            b_seen[b.row*MAX_N + b.col] = 1'b1;
        // dropped beats do not count toward the random quota
        if (m != MODE_UNUSED)
            queued++;
    endfunction

    // well-formed sequence: fill one row of A and one column of B with
    // random content, in a shuffled order, then ask for their dot product
    function automatic void queue_dot_sequence();
        int r, c, n, br, bc, c2;
        r = $urandom_range(MAX_N-1);
        c = $urandom_range(MAX_N-1);
        n = terms_in_use();
        for (int k = 0; k < n; k++)
        begin
            br = col_major ? c : k;
            bc = col_major ? k : c;
            if ($urandom_range(1))
            begin
                queue_beat(smm_pkg::MODE_WRITE_A, r, k, pick_element());
                queue_beat(smm_pkg::MODE_WRITE_B, br, bc, pick_element());
            end
            else
            begin
                queue_beat(smm_pkg::MODE_WRITE_B, br, bc, pick_element());
                queue_beat(smm_pkg::MODE_WRITE_A, r, k, pick_element());
            end
            if ($urandom_range(19) == 0)
                queue_beat(MODE_UNUSED, $urandom_range(MAX_N-1), $urandom_range(MAX_N-1),
                           smm_pkg::VALUE_W'($urandom));
        end
        queue_beat(smm_pkg::MODE_READ_C, r, c, smm_pkg::VALUE_W'($urandom));
        c2 = $urandom_range(MAX_N-1);
        if ($urandom_range(1) && entry_readable(r, c2))
            queue_beat(smm_pkg::MODE_READ_C, r, c2, smm_pkg::VALUE_W'($urandom));
    endfunction

    // a run of reads over whatever entries are already fully written
    function automatic void queue_read_burst();
        int cnt, r, c;
        cnt = $urandom_range(2, 8);
        for (int i = 0; i < cnt; i++)
        begin
            for (int tries = 0; tries < 40; tries++)
            begin
                r = $urandom_range(MAX_N-1);
                c = $urandom_range(MAX_N-1);
                if (entry_readable(r, c))
                begin
                    queue_beat(smm_pkg::MODE_READ_C, r, c, smm_pkg::VALUE_W'($urandom));
                    break;
                end
            end
        end
    endfunction

    // stray writes anywhere and beats of the unused mode
    function automatic void queue_noise();
        case ($urandom_range(2))
            0:       queue_beat(MODE_UNUSED, $urandom_range(MAX_N-1), $urandom_range(MAX_N-1),
                                smm_pkg::VALUE_W'($urandom));
            1:       queue_beat(smm_pkg::MODE_WRITE_A, $urandom_range(MAX_N-1),
                                $urandom_range(MAX_N-1), pick_element());
            default: queue_beat(smm_pkg::MODE_WRITE_B, $urandom_range(MAX_N-1),
                                $urandom_range(MAX_N-1), pick_element());
        endcase
    endfunction

    // hold the sender until everything queued is sent and answered, then
    // give the core time to finish any write or dropped beat
    task automatic settle();
        do
            @(negedge clk);
        while (matrix_beats.size() != 0 || in_valid || c_entries_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        pauses++;
    endtask

    // both registers, written only with the core idle
    task automatic set_config(int size, bit cm);
        settle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= smm_pkg::REG_SIZE_IN_USE;
        cfg_data  <= size[smm_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= smm_pkg::REG_B_COLUMN_MAJOR;
        cfg_data  <= smm_pkg::CFG_DATA_W'(cm);
        @(posedge clk);
        cfg_write <= 1'b0;
        size_reg  = size[smm_pkg::SIZE_W-1:0];
        col_major = cm;
        settings_used++;
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // sender: bursts of beats with gaps between them; a stalled beat is held
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // a beat taken at this edge goes to the predictor
            if (in_valid && !in_stall)
                apply_matrix_beat('{mode, row, col, value});
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (matrix_beats.size() != 0)
                begin
                    next_beat = matrix_beats.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= next_beat.mode;
                    row       <= next_beat.row;
                    col       <= next_beat.col;
                    value     <= next_beat.value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // mostly short gaps, sometimes long ones, sometimes none for a while
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(9))
                            0:
                            begin
                                gap_left   = 0;
                                burst_left = $urandom_range(40, 120);
                            end
                            1:       gap_left = $urandom_range(10, 40);
                            default: gap_left = $urandom_range(0, 4);
                        endcase
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result beat against the oldest owed entry and
    // stalls at a rate that is picked anew each time stall_age reaches STALL_SPAN
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (c_entries_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: extra result beat, expected none, actual %0d (%0d,%0d)",
                             $time, product, out_row, out_col);
                end
                else
                begin
                    due = c_entries_due.pop_front();
                    check_field("product", due.product, product);
                    check_field("out_row", due.row, out_row);
                    check_field("out_col", due.col, out_col);
                    results_seen++;
                end
            end
            stall_age++;
            if (stall_age >= STALL_SPAN)
            begin
                stall_age = 0;
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: too long with nothing moving on any port means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d entries still owed",
                         $time, quiet_cycles, c_entries_due.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-term products of the extreme elements
        set_config(1, 1'b0);
        queue_beat(smm_pkg::MODE_WRITE_A, 0, 0, -16'sd32768);
        queue_beat(smm_pkg::MODE_WRITE_B, 0, 0, -16'sd32768);
        queue_beat(smm_pkg::MODE_READ_C, 0, 0, '0);
        queue_beat(smm_pkg::MODE_WRITE_A, 15, 0, 16'sd32767);
        queue_beat(smm_pkg::MODE_WRITE_B, 0, 15, 16'sd32767);
        // entries outside the size in use are still computed
        queue_beat(smm_pkg::MODE_READ_C, 15, 15, 16'sd32767);
        queue_beat(smm_pkg::MODE_READ_C, 15, 0, -16'sd1);
        queue_beat(smm_pkg::MODE_READ_C, 0, 15, '0);
        // unused mode is dropped with no result
        queue_beat(MODE_UNUSED, 15, 15, -16'sd1);
        queue_beat(smm_pkg::MODE_WRITE_A, 0, 0, -16'sd1);
        queue_beat(smm_pkg::MODE_READ_C, 0, 0, '0);

        // size zero: empty sum, never touches the stores
        set_config(0, 1'b1);
        queue_beat(smm_pkg::MODE_READ_C, 7, 9, '0);
        queue_beat(smm_pkg::MODE_READ_C, 15, 15, -16'sd1);

        // two terms with B held transposed
        set_config(2, 1'b1);
        queue_beat(smm_pkg::MODE_WRITE_A, 0, 1, 16'sd32767);
        queue_beat(smm_pkg::MODE_WRITE_B, 0, 1, -16'sd32768);
        queue_beat(smm_pkg::MODE_READ_C, 0, 0, '0);

        // random: one setting per phase; odd phases also pause the sender
        // half way until every owed entry has come back
        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            set_config(phase_size[phase % NUM_PHASES], phase_cm[phase % NUM_PHASES]);
            phase_start = queued;
            for (int half = 1; half <= 2; half++)
            begin
                while (queued < phase_start + half*PHASE_ITEMS/2)
                begin
                    pick = $urandom_range(99);
                    if (pick < 55)
                        queue_dot_sequence();
                    else if (pick < 85)
                        queue_read_burst();
                    else
                        queue_noise();
                end
                if (half == 1 && phase % 2 == 1)
                    settle();
            end
            phase++;
        end
        settle();

        $display("covered %0d element writes, %0d product reads and %0d dropped beats",
                 write_beats, read_beats, ignored_beats);
        $display("over %0d size/layout settings, %0d results checked, %0d mismatches",
                 settings_used, results_seen, errors);
        if (errors == 0 && c_entries_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
